[design/rss_pkg.sv]
// Shared types and constants for the running sample statistics block.
package rss_pkg;

	localparam int SAMPLE_W = 16;
	localparam int TALLY_W  = 16;
	localparam int TOTAL_W  = 32;
	localparam int SQ_W     = 46;
	localparam int VAR_W    = 31;
	localparam int DEV_W    = 16;
	localparam int OUT_W    = 144;

	localparam logic [TALLY_W-1:0]  TALLY_FULL = {TALLY_W{1'b1}};
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
	localparam logic [VAR_W-1:0]    VAR_MAX    = {VAR_W{1'b1}};

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SQ   = 9'b000000010,
		ST_LO   = 9'b000000100,
		ST_HI   = 9'b000001000,
		ST_DEN  = 9'b000010000,
		ST_MDIV = 9'b000100000,
		ST_VDIV = 9'b001000000,
		ST_ROOT = 9'b010000000,
		ST_DONE = 9'b100000000
	} rss_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rss_status_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] mean;
		logic [VAR_W-1:0]    var_q16;
		logic [DEV_W-1:0]    dev;
	} rss_result_t;

endpackage

[design/rss_arith.sv]
// Sequenced mean, variance and square root over one shared multiplier and subtractor.
module rss_arith (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [rss_pkg::TALLY_W-1:0]     n,
	input  logic signed [rss_pkg::TOTAL_W-1:0] sum,
	input  logic [rss_pkg::SQ_W-1:0]        sumsq,
	input  logic                            take,
	output rss_pkg::rss_status_t            status,
	output rss_pkg::rss_result_t            res
);

	rss_pkg::rss_state_t state_q;
	logic [5:0]  cnt_q;
	logic [15:0] n_q;
	logic [31:0] mag_q;
	logic        neg_q;
	logic [45:0] sq_q;
	logic [63:0] sum2_q;
	logic [63:0] nsq_q;
	logic [63:0] num_q;
	logic [31:0] den_q;
	logic [31:0] div_q;
	logic [31:0] rem_q;
	logic [63:0] quo_q;
	logic [31:0] v_q;
	logic [31:0] root_q;
	logic [30:0] bit_q;
	logic [15:0] mean_q;
	logic [30:0] var_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [32:0] rem_sh;
	logic [31:0] trial;
	logic [32:0] opa;
	logic [32:0] opb;
	logic [33:0] diff;
	logic        ge;
	logic [31:0] quo_lo_next;
	logic [63:0] quo_next;
	logic [31:0] mean_wide;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			rss_pkg::ST_SQ: begin
				mul_a = mag_q;
				mul_b = mag_q;
			end
			rss_pkg::ST_LO: begin
				mul_a = {16'b0, n_q};
				mul_b = sq_q[31:0];
			end
			rss_pkg::ST_HI: begin
				mul_a = {16'b0, n_q};
				mul_b = {18'b0, sq_q[45:32]};
			end
			rss_pkg::ST_DEN: begin
				mul_a = {16'b0, n_q};
				mul_b = {16'b0, n_q - 16'd1};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod   = mul_a * mul_b;
	assign rem_sh = {rem_q, quo_q[63]};
	assign trial  = root_q + {1'b0, bit_q};
	assign opa    = (state_q == rss_pkg::ST_ROOT) ? {1'b0, v_q} : rem_sh;
	assign opb    = (state_q == rss_pkg::ST_ROOT) ? {1'b0, trial} : {1'b0, div_q};
	assign diff   = {1'b0, opa} - {1'b0, opb};
	assign ge     = ~diff[33];
	assign quo_next    = {quo_q[62:0], ge};
	assign quo_lo_next = quo_next[31:0];
	assign mean_wide   = neg_q ? (32'd0 - quo_lo_next) : quo_lo_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rss_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				rss_pkg::ST_IDLE: begin
					if (start)
						state_q <= rss_pkg::ST_SQ;
				end
				rss_pkg::ST_SQ:  state_q <= rss_pkg::ST_LO;
				rss_pkg::ST_LO:  state_q <= rss_pkg::ST_HI;
				rss_pkg::ST_HI:  state_q <= rss_pkg::ST_DEN;
				rss_pkg::ST_DEN: begin
					state_q <= rss_pkg::ST_MDIV;
					cnt_q   <= 6'd31;
				end
				rss_pkg::ST_MDIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						if (n_q < 16'd2) begin
							state_q <= rss_pkg::ST_DONE;
						end else begin
							state_q <= rss_pkg::ST_VDIV;
							cnt_q   <= 6'd63;
						end
					end
				end
				rss_pkg::ST_VDIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						state_q <= rss_pkg::ST_ROOT;
						cnt_q   <= 6'd15;
					end
				end
				rss_pkg::ST_ROOT: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd0)
						state_q <= rss_pkg::ST_DONE;
				end
				rss_pkg::ST_DONE: begin
					if (take)
						state_q <= rss_pkg::ST_IDLE;
				end
				default: state_q <= rss_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			rss_pkg::ST_IDLE: begin
				if (start) begin
					n_q   <= n;
					neg_q <= sum[31];
					mag_q <= sum[31] ? (32'd0 - sum) : sum;
					sq_q  <= sumsq;
				end
			end
			rss_pkg::ST_SQ: sum2_q <= prod;
			rss_pkg::ST_LO: nsq_q  <= prod;
			rss_pkg::ST_HI: nsq_q  <= nsq_q + {prod[31:0], 32'b0};
			rss_pkg::ST_DEN: begin
				den_q <= prod[31:0];
				num_q <= (nsq_q > sum2_q) ? (nsq_q - sum2_q) : 64'd0;
				rem_q <= '0;
				quo_q <= {mag_q, 32'b0};
				div_q <= {16'b0, n_q};
			end
			rss_pkg::ST_MDIV: begin
				rem_q <= ge ? diff[31:0] : rem_sh[31:0];
				quo_q <= quo_next;
				if (cnt_q == 6'd0) begin
					mean_q <= mean_wide[15:0];
					var_q  <= '0;
					root_q <= '0;
					rem_q  <= '0;
					quo_q  <= num_q;
					div_q  <= den_q;
				end
			end
			rss_pkg::ST_VDIV: begin
				rem_q <= ge ? diff[31:0] : rem_sh[31:0];
				quo_q <= quo_next;
				if (cnt_q == 6'd0) begin
					if (|quo_next[63:31]) begin
						var_q <= rss_pkg::VAR_MAX;
						v_q   <= {1'b0, rss_pkg::VAR_MAX};
					end else begin
						var_q <= quo_next[30:0];
						v_q   <= {1'b0, quo_next[30:0]};
					end
					root_q <= '0;
					bit_q  <= 31'h40000000;
				end
			end
			rss_pkg::ST_ROOT: begin
				if (ge) begin
					v_q    <= diff[31:0];
					root_q <= (root_q >> 1) + {1'b0, bit_q};
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: begin
			end
		endcase
	end

	assign status.busy  = (state_q != rss_pkg::ST_IDLE);
	assign status.done  = (state_q == rss_pkg::ST_DONE);
	assign res.mean     = mean_q;
	assign res.var_q16  = var_q;
	assign res.dev      = root_q[15:0];

	property p_start_idle;
		@(posedge clk) disable iff (!arst_n)
		start |-> state_q == rss_pkg::ST_IDLE;
	endproperty
	a_start_idle: assert property (p_start_idle)
		else $error("start while sequencer busy");

	property p_rem_below;
		@(posedge clk) disable iff (!arst_n)
		(state_q == rss_pkg::ST_MDIV || state_q == rss_pkg::ST_VDIV) |-> rem_q < div_q;
	endproperty
	a_rem_below: assert property (p_rem_below)
		else $error("divider remainder not below divisor");

	property p_root_done;
		@(posedge clk) disable iff (!arst_n)
		(state_q == rss_pkg::ST_DONE) |-> root_q[31:16] == 16'd0;
	endproperty
	a_root_done: assert property (p_root_done)
		else $error("square root wider than result");

endmodule

[design/running_sample_statistics.sv]
// Top level of the running sample statistics block: set registers, handshakes, result register.
//
//  channel  dir  payload                                        accept
//  s_*      in   tdata: sample; tuser: start_new                s_tvalid & s_tready
//  m_*      out  tdata: seven statistics; tuser: saturated      m_tvalid & m_tready
//
// One sample at a time: s_tready drops at accept and returns once the result enters
// the output register, after four multiplies, a 32-step mean divide, a 64-step
// variance divide and a 16-step root on the shared unit.
// With fewer than two samples the variance divide and root are skipped.
// Reset empties the set; a stalled result holds in the output register.
module running_sample_statistics (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [15:0]  s_tdata,   // [15:0] sample
	input  logic         s_tuser,   // [0] start_new
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [143:0] m_tdata,   // [15:0] items_seen, [47:16] total, [63:48] average,
	                                // [94:64] spread_squared, [110:95] deviation,
	                                // [126:111] smallest, [142:127] largest, [143] zero
	output logic         m_tuser    // [0] saturated
);

	logic [15:0] tally_q;
	logic [31:0] total_q;
	logic [45:0] sq_q;
	logic [15:0] low_q;
	logic [15:0] high_q;
	logic        sat_q;
	logic        busy_q;
	logic        start_q;
	logic        m_tvalid_q;
	logic [142:0] m_data_q;
	logic        m_sat_q;

	logic        s_acc;
	logic        load;
	logic [15:0] b_tally;
	logic [31:0] b_total;
	logic [45:0] b_sq;
	logic [15:0] b_low;
	logic [15:0] b_high;
	logic        drop;
	logic signed [31:0] smp_sq;
	rss_pkg::rss_status_t st;
	rss_pkg::rss_result_t res;

	assign s_tready = ~busy_q;
	assign s_acc    = s_tvalid & s_tready;
	assign load     = st.done & (~m_tvalid_q | m_tready);

	assign b_tally = s_tuser ? 16'd0 : tally_q;
	assign b_total = s_tuser ? 32'd0 : total_q;
	assign b_sq    = s_tuser ? 46'd0 : sq_q;
	assign b_low   = s_tuser ? rss_pkg::SAMPLE_MAX : low_q;
	assign b_high  = s_tuser ? rss_pkg::SAMPLE_MIN : high_q;
	assign drop    = (b_tally == rss_pkg::TALLY_FULL);
	assign smp_sq  = $signed(s_tdata) * $signed(s_tdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q    <= '0;
			total_q    <= '0;
			sq_q       <= '0;
			low_q      <= rss_pkg::SAMPLE_MAX;
			high_q     <= rss_pkg::SAMPLE_MIN;
			busy_q     <= 1'b0;
			start_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			start_q <= s_acc;
			if (s_acc) begin
				busy_q <= 1'b1;
				if (drop) begin
					tally_q <= b_tally;
					total_q <= b_total;
					sq_q    <= b_sq;
					low_q   <= b_low;
					high_q  <= b_high;
				end else begin
					tally_q <= b_tally + 16'd1;
					total_q <= b_total + {{16{s_tdata[15]}}, s_tdata};
					sq_q    <= b_sq + {14'b0, smp_sq};
					low_q   <= ($signed(s_tdata) < $signed(b_low)) ? s_tdata : b_low;
					high_q  <= ($signed(s_tdata) > $signed(b_high)) ? s_tdata : b_high;
				end
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc)
			sat_q <= drop;
		if (load) begin
			m_data_q <= {high_q, low_q, res.dev, res.var_q16, res.mean, total_q, tally_q};
			m_sat_q  <= sat_q;
		end
	end

	rss_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.n      (tally_q),
		.sum    ($signed(total_q)),
		.sumsq  (sq_q),
		.take   (load),
		.status (st),
		.res    (res)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_data_q};
	assign m_tuser  = m_sat_q;

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n)
		st.busy |-> ~s_tready;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy)
		else $error("input ready while arithmetic runs");

	property p_start_follows;
		@(posedge clk) disable iff (!arst_n)
		s_acc |=> start_q;
	endproperty
	a_start_follows: assert property (p_start_follows)
		else $error("accepted sample did not launch arithmetic");

	property p_sat_full;
		@(posedge clk) disable iff (!arst_n)
		(m_tvalid & m_tuser) |-> m_tdata[15:0] == rss_pkg::TALLY_FULL;
	endproperty
	a_sat_full: assert property (p_sat_full)
		else $error("dropped sample reported with count not full");

	property p_small_set;
		@(posedge clk) disable iff (!arst_n)
		(m_tvalid & (m_tdata[15:0] < 16'd2)) |-> m_tdata[110:64] == 47'd0;
	endproperty
	a_small_set: assert property (p_small_set)
		else $error("variance or deviation nonzero below two samples");

	property p_root_bound;
		@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ({16'b0, m_tdata[110:95]} * {16'b0, m_tdata[110:95]})
			<= {1'b0, m_tdata[94:64]};
	endproperty
	a_root_bound: assert property (p_root_bound)
		else $error("deviation squared exceeds variance");

endmodule

[tb/running_sample_statistics_test.sv]
// Testbench for running_sample_statistics: stream-driven samples checked against a set predictor.
`timescale 1ns / 100ps
module running_sample_statistics_test;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_ITEMS = 750;
	localparam int SETTLE_CYCLES = 200;

	typedef struct {
		logic [rss_pkg::TALLY_W-1:0]  items_seen;
		logic [rss_pkg::TOTAL_W-1:0]  total;
		logic [rss_pkg::SAMPLE_W-1:0] average;
		logic [rss_pkg::VAR_W-1:0]    spread_squared;
		logic [rss_pkg::DEV_W-1:0]    deviation;
		logic [rss_pkg::SAMPLE_W-1:0] smallest;
		logic [rss_pkg::SAMPLE_W-1:0] largest;
		logic                         saturated;
	} set_summary_t;

	class stats_predictor;
		logic [rss_pkg::TALLY_W-1:0]         tally;
		logic [rss_pkg::TOTAL_W-1:0]         total;
		logic [rss_pkg::SQ_W-1:0]            square_sum;
		logic signed [rss_pkg::SAMPLE_W-1:0] low_mark;
		logic signed [rss_pkg::SAMPLE_W-1:0] high_mark;
		set_summary_t                        expected_summaries[$];
		int                                  mismatch_count;

		function new();
			empty_set();
			mismatch_count = 0;
		endfunction

		function void empty_set();
			tally      = '0;
			total      = '0;
			square_sum = '0;
			low_mark   = rss_pkg::SAMPLE_MAX;
			high_mark  = rss_pkg::SAMPLE_MIN;
		endfunction

		function logic [rss_pkg::DEV_W-1:0] root_floor(logic [rss_pkg::VAR_W-1:0] v);
			logic [rss_pkg::DEV_W-1:0] r;
			logic [rss_pkg::DEV_W-1:0] trial;
			longint unsigned           t;
			r = '0;
			for (int b = rss_pkg::DEV_W - 1; b >= 0; b--) begin
				trial    = r;
				trial[b] = 1'b1;
				t = trial;
				if (t * t <= v)
					r = trial;
			end
			return r;
		endfunction

		function void take_sample(logic signed [rss_pkg::SAMPLE_W-1:0] s, logic start_new);
			set_summary_t    e;
			longint          sum_v;
			longint          mean_v;
			longint unsigned sq_v;
			longint unsigned n_u;
			longint unsigned mag;
			longint unsigned sum_sq;
			longint unsigned weighted;
			longint unsigned num;
			longint unsigned q;
			e.saturated = 1'b0;
			if (start_new)
				empty_set();
			if (tally == rss_pkg::TALLY_FULL) begin
				e.saturated = 1'b1;
			end else begin
				tally      = tally + 1'b1;
				total      = total + {{(rss_pkg::TOTAL_W-rss_pkg::SAMPLE_W){s[rss_pkg::SAMPLE_W-1]}},
					s};
				sq_v       = longint'(s) * longint'(s);
				square_sum = square_sum + sq_v[rss_pkg::SQ_W-1:0];
				if (s > high_mark)
					high_mark = s;
				if (s < low_mark)
					low_mark = s;
			end
			n_u    = tally;
			sum_v  = longint'($signed(total));
			mean_v = (n_u != 0) ? (sum_v / longint'(n_u)) : 0;
			e.average        = mean_v[rss_pkg::SAMPLE_W-1:0];
			e.spread_squared = '0;
			e.deviation      = '0;
			if (n_u >= 2) begin
				mag      = (sum_v < 0) ? -sum_v : sum_v;
				sum_sq   = mag * mag;
				weighted = n_u * square_sum;
				num      = (weighted > sum_sq) ? weighted - sum_sq : 0;
				q        = num / (n_u * (n_u - 1));
				if (q > rss_pkg::VAR_MAX)
					q = rss_pkg::VAR_MAX;
				e.spread_squared = q[rss_pkg::VAR_W-1:0];
				e.deviation      = root_floor(e.spread_squared);
			end
			e.items_seen = tally;
			e.total      = total;
			e.smallest   = low_mark;
			e.largest    = high_mark;
			expected_summaries.push_back(e);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				mismatch_count++;
			end
		endfunction

		function void check_summary(logic [rss_pkg::OUT_W-1:0] data, logic sat);
			set_summary_t e;
			if (expected_summaries.size() == 0) begin
				$error("summary transaction with no sample outstanding");
				mismatch_count++;
				return;
			end
			e = expected_summaries.pop_front();
			compare_field("items_seen", e.items_seen, data[15:0]);
			compare_field("total", e.total, data[47:16]);
			compare_field("average", e.average, data[63:48]);
			compare_field("spread_squared", e.spread_squared, data[94:64]);
			compare_field("deviation", e.deviation, data[110:95]);
			compare_field("smallest", e.smallest, data[126:111]);
			compare_field("largest", e.largest, data[142:127]);
			compare_field("pad", 64'd0, data[143]);
			compare_field("saturated", e.saturated, sat);
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [15:0]               s_tdata = '0;
	logic                      s_tuser = 1'b0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [rss_pkg::OUT_W-1:0] m_tdata;
	logic                      m_tuser;

	stats_predictor model = new();

	int  burst_left = 0;
	bit  rx_ready = 1'b0;
	int  rx_left = 0;
	int  cycle_count = 0;

	running_sample_statistics u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: check each accepted transaction, then pick the next stall pattern step.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			model.check_summary(m_tdata, m_tuser);
		if (rx_left == 0) begin
			rx_ready = !rx_ready;
			if (rx_ready)
				rx_left = $urandom_range(1, 40);
			else if ($urandom_range(0, 3) == 0)
				rx_left = $urandom_range(20, 150);
			else
				rx_left = $urandom_range(1, 6);
		end
		rx_left--;
		m_tready <= rx_ready;
	end

	task automatic push_sample(logic [15:0] value, logic start_new);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tuser  <= start_new;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		model.take_sample(value, start_new);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (model.expected_summaries.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample(logic [15:0] cluster);
		logic [15:0] extremes [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 5)
			return 16'($urandom);
		else if (kind == 5)
			return extremes[$urandom_range(0, 3)];
		else if (kind < 8)
			return 16'($urandom_range(0, 512) - 256);
		else
			return cluster + 16'($urandom_range(0, 31));
	endfunction

	initial begin
		logic [16:0] directed [21];
		logic [15:0] cluster;
		bit          short_sets;
		logic        start_new;

		directed = '{
			{1'b0, 16'h0100}, {1'b0, 16'h7FFF}, {1'b0, 16'h8000}, {1'b0, 16'h0000},
			{1'b0, 16'hFFFF}, {1'b0, 16'h0001}, {1'b1, 16'h8000}, {1'b1, 16'h7FFF},
			{1'b0, 16'h8000}, {1'b0, 16'h7FFF}, {1'b0, 16'h8000}, {1'b1, 16'hFFFD},
			{1'b0, 16'hFFFE}, {1'b1, 16'h0003}, {1'b0, 16'h0002}, {1'b1, 16'h5555},
			{1'b0, 16'hAAAA}, {1'b0, 16'h5555}, {1'b1, 16'h1234}, {1'b0, 16'h1234},
			{1'b0, 16'h1234}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			push_sample(directed[i][15:0], directed[i][16]);
		wait_drained();

		cluster    = 16'($urandom);
		short_sets = 1'b0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 50 == 0)
				short_sets = $urandom_range(0, 1);
			start_new = short_sets ? ($urandom_range(0, 2) == 0) : ($urandom_range(0, 39) == 0);
			if (start_new)
				cluster = 16'($urandom);
			if (i == RANDOM_ITEMS / 2)
				wait_drained();
			push_sample(pick_sample(cluster), start_new);
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (model.mismatch_count == 0 && model.expected_summaries.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[running_sample_statistics.f]
design/rss_pkg.sv
design/rss_arith.sv
design/running_sample_statistics.sv
tb/running_sample_statistics_test.sv
